>>> sv/mpwr_pkg.sv
// shared types, constants and register codes of the word replacer
package mpwr_pkg;

    localparam int SLOTS_DEFAULT     = 4;
    localparam int MAX_BYTES_DEFAULT = 8;
    localparam int WORD_W            = 64;
    localparam int LEN_W             = 4;
    localparam int BYTE_W            = 8;
    localparam int REPL_IDX_W        = 3;
    localparam int CFG_INDEX_W       = 3;
    localparam int CMD_FIFO_DEPTH    = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTHS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPL_WORD       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPL_LENGTH     = 3'd6;

    localparam logic [WORD_W-1:0] REPL_WORD_RESET   = 64'h0000_006B_6177_616C;
    localparam logic [LEN_W-1:0]  REPL_LENGTH_RESET = 4'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              text_last;
    } text_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } result_t;

    // one decision from the front: copy a byte or emit the replacement word
    typedef struct packed {
        logic              is_repl;
        logic [BYTE_W-1:0] data;
        logic              last;
    } cmd_t;

    typedef enum logic [0:0] {
        BACK_IDLE,
        BACK_EMIT
    } back_state_t;

endpackage

>>> sv/multi_pattern_word_replacer_unit.sv
// Streaming word replacer. Text bytes are pushed in and filtered bytes popped out, one beat per
// byte. The input keeps accepting bytes while copies flow; each pattern match emits
// replacement_length bytes (zero counts as one, anything past eight as eight), one per cycle
// from the back end while the output register is free or popped, so a match holds the input
// once the two-entry decision queue fills. A beat marked text_last starts a flush that issues
// one decision per cycle while the decision queue has room, until the lookahead window is empty,
// and keeps full high meanwhile; the final filtered byte carries out_last. The decision taken on
// the push that brings the window to MAX_PATTERN_BYTES bytes passes through the decision queue,
// the back end's command register and the output register before it can be popped.
// Configuration writes are taken every cycle and must only happen while the block is idle.
module multi_pattern_word_replacer_unit
    import mpwr_pkg::*;
#(
    parameter int PATTERN_SLOTS     = SLOTS_DEFAULT,
    parameter int MAX_PATTERN_BYTES = MAX_BYTES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  text_t                  text,
    output logic                   full,
    input  logic                   pop,
    output result_t                result,
    output logic                   empty,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    logic [PATTERN_SLOTS-1:0][WORD_W-1:0] pattern_reg;
    logic [4*LEN_W-1:0]                   lengths_reg;
    logic [WORD_W-1:0]                    repl_word_reg;
    logic [LEN_W-1:0]                     repl_len_reg;
    logic [LEN_W-1:0]                     repl_len_m1;
    logic [REPL_IDX_W-1:0]                repl_last_idx;
    logic                                 cfg_fire;

    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_full;
    logic cmd_empty;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // zero counts as one byte, anything past eight as eight
    assign repl_len_m1   = repl_len_reg - LEN_W'(1);
    assign repl_last_idx = (repl_len_reg == '0) ? '0
                         : (repl_len_reg > LEN_W'(8)) ? '1
                         : repl_len_m1[REPL_IDX_W-1:0];

    for (genvar i = 0; i < PATTERN_SLOTS; i++)
    begin : g_pattern
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pattern_reg[i] <= '0;
            end
            else if (cfg_fire && (cfg_index == CFG_INDEX_W'(i)))
            begin
                pattern_reg[i] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lengths_reg   <= '0;
            repl_word_reg <= REPL_WORD_RESET;
            repl_len_reg  <= REPL_LENGTH_RESET;
        end
        else if (cfg_fire)
        begin
            if (cfg_index == CFG_PATTERN_LENGTHS)
            begin
                lengths_reg <= cfg_data[4*LEN_W-1:0];
            end
            if (cfg_index == CFG_REPL_WORD)
            begin
                repl_word_reg <= cfg_data;
            end
            if (cfg_index == CFG_REPL_LENGTH)
            begin
                repl_len_reg <= cfg_data[LEN_W-1:0];
            end
        end
    end

    mpwr_front #(
        .PATTERN_SLOTS     (PATTERN_SLOTS),
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .text            (text),
        .full            (full),
        .pattern_words   (pattern_reg),
        .pattern_lengths (lengths_reg),
        .cmd_push        (cmd_push),
        .cmd             (cmd_in),
        .cmd_full        (cmd_full)
    );

    mpwr_cmd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    mpwr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_out),
        .cmd_empty     (cmd_empty),
        .cmd_pop       (cmd_pop),
        .repl_word     (repl_word_reg),
        .repl_last_idx (repl_last_idx),
        .pop           (pop),
        .empty         (empty),
        .result        (result)
    );

endmodule

>>> sv/mpwr_cmd_fifo.sv
// small register queue of decisions between front and back
module mpwr_cmd_fifo
    import mpwr_pkg::*;
#(
    parameter int WIDTH = 10,
    parameter int DEPTH = CMD_FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/mpwr_front.sv
// front end: lookahead window, pattern match and decision issue
module mpwr_front
    import mpwr_pkg::*;
#(
    parameter int PATTERN_SLOTS     = SLOTS_DEFAULT,
    parameter int MAX_PATTERN_BYTES = MAX_BYTES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  text_t                               text,
    output logic                                full,
    input  logic [PATTERN_SLOTS-1:0][WORD_W-1:0] pattern_words,
    input  logic [4*LEN_W-1:0]                  pattern_lengths,
    output logic                                cmd_push,
    output cmd_t                                cmd,
    input  logic                                cmd_full
);

    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

    logic [BYTE_W-1:0] window_reg  [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] window_next [MAX_PATTERN_BYTES];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              flush_reg, flush_next;

    logic [LEN_W-1:0]         slot_len [PATTERN_SLOTS];
    logic [PATTERN_SLOTS-1:0] slot_hit;
    logic [FILL_W-1:0]        match_len;
    logic [FILL_W-1:0]        drop;
    logic [FILL_W-1:0]        left;
    logic [FILL_W-1:0]        wr_idx;
    logic                     dec_go;
    logic                     acc;

    // per slot compare against the head of the window
    always_comb
    begin
        for (int i = 0; i < PATTERN_SLOTS; i++)
        begin
            slot_len[i] = pattern_lengths[LEN_W*i +: LEN_W];
            slot_hit[i] = (slot_len[i] != '0)
                       && (int'(slot_len[i]) <= MAX_PATTERN_BYTES)
                       && (slot_len[i] <= LEN_W'(fill_reg));
            for (int k = 0; k < MAX_PATTERN_BYTES; k++)
            begin
                if ((k < int'(slot_len[i]))
                    && (window_reg[k] != pattern_words[i][BYTE_W*k +: BYTE_W]))
                begin
                    slot_hit[i] = 1'b0;
                end
            end
        end
    end

    // lowest slot wins
    always_comb
    begin
        match_len = '0;
        for (int i = PATTERN_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_hit[i])
            begin
                match_len = FILL_W'(slot_len[i]);
            end
        end
    end

    assign dec_go = (flush_reg || (fill_reg == FILL_W'(MAX_PATTERN_BYTES))) && !cmd_full;
    assign full   = flush_reg || ((fill_reg == FILL_W'(MAX_PATTERN_BYTES)) && !dec_go);
    assign acc    = push && !full;
    assign drop   = !dec_go ? '0 : ((match_len != '0) ? match_len : FILL_W'(1));
    assign left   = fill_reg - drop;
    assign wr_idx = left;

    assign cmd_push     = dec_go;
    assign cmd.is_repl  = (match_len != '0);
    assign cmd.data     = window_reg[0];
    assign cmd.last     = flush_reg && (left == '0);

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            window_next[k] = window_reg[k];
            for (int j = 1; j < MAX_PATTERN_BYTES - k; j++)
            begin
                if (drop == FILL_W'(j))
                begin
                    window_next[k] = window_reg[k + j];
                end
            end
            if (acc && (FILL_W'(k) == wr_idx))
            begin
                window_next[k] = text.text_byte;
            end
        end
        fill_next  = left + FILL_W'(acc);
        flush_next = flush_reg;
        if (acc && text.text_last)
        begin
            flush_next = 1'b1;
        end
        else if (dec_go && flush_reg && (left == '0))
        begin
            flush_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            flush_reg <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            window_reg[k] <= window_next[k];
        end
    end

endmodule

>>> sv/mpwr_back.sv
// back end: expands decisions into output bytes behind an output register
module mpwr_back
    import mpwr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic                  cmd_empty,
    output logic                  cmd_pop,
    input  logic [WORD_W-1:0]     repl_word,
    input  logic [REPL_IDX_W-1:0] repl_last_idx,
    input  logic                  pop,
    output logic                  empty,
    output result_t               result
);

    back_state_t             state_reg, state_next;
    cmd_t                    cmd_reg;
    logic [REPL_IDX_W-1:0]   idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 result_reg;
    logic                    slot_free;
    logic                    done;
    logic                    emit;
    result_t                 emit_beat;

    assign slot_free = !out_valid_reg || pop;
    assign done      = !cmd_reg.is_repl || (idx_reg == repl_last_idx);
    assign empty     = !out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = BACK_EMIT;
                end
            end
            BACK_EMIT:
            begin
                if (slot_free && done && cmd_empty)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit    = 1'b0;
        cmd_pop = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                cmd_pop = !cmd_empty;
            end
            BACK_EMIT:
            begin
                emit    = slot_free;
                cmd_pop = slot_free && done && !cmd_empty;
            end
            default:
            begin
                emit    = 1'b0;
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        emit_beat.out_byte = cmd_reg.is_repl ? repl_word[BYTE_W*idx_reg +: BYTE_W] : cmd_reg.data;
        emit_beat.out_last = cmd_reg.last && done;
        idx_next           = idx_reg;
        if (cmd_pop)
        begin
            idx_next = '0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + REPL_IDX_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (emit)
        begin
            result_reg <= emit_beat;
        end
    end

endmodule

>>> sv/mpwr_checker.sv
// port level checks of the word replacer and their binding
module mpwr_checker
    import mpwr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    push,
    input text_t   text,
    input logic    full,
    input logic    pop,
    input result_t result,
    input logic    empty
);

    // a waiting beat stays put until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result beat changed or vanished while stalled");

    // accepting the final byte starts a flush that blocks further input
    a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && text.text_last) |=> full)
        else $error("input not blocked after final byte");

    // with no new byte the input side never closes by itself
    a_no_spurious_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full raised without an accepted byte");

endmodule

bind multi_pattern_word_replacer_unit mpwr_checker u_mpwr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .text   (text),
    .full   (full),
    .pop    (pop),
    .result (result),
    .empty  (empty)
);
